// ===== sv/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared clocked assertion forms for the event table dispatch RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ETMD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ETMD_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

// ===== sv/etmd_pkg.sv =====
// ============================================================================
// etmd_pkg
// Types, codes and constants of the event table match/dispatch block.
// ============================================================================
`default_nettype none

package etmd_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_FRAME_SIZE  = 25;

    // big-endian tag index and event id positions inside a frame
    localparam int INDEX_POS  = 4;
    localparam int EVENT_POS  = 8;
    localparam int WORD_BYTES = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 104;
    localparam int M_PAD_W   = M_TDATA_W - 97;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_DEL  = 2'd1;
    localparam logic [1:0] CMD_BYTE = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_PARTIAL  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_DEL,
        OP_MATCH,
        OP_PARTIAL,
        OP_NOP
    } op_kind_t;

    // decoded request handed from front to back
    typedef struct packed {
        op_kind_t    kind;
        logic [31:0] tag;
        logic [31:0] evt;
        logic [31:0] handle;
        logic        has_handler;
    } op_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] evt;
        logic [31:0] handle;
        logic        has_handler;
    } entry_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] index;
        logic [31:0] evt;
        logic [31:0] handle;
        logic        call;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/event_table_match_dispatch.sv =====
// Add, non-final message byte and unused code give a result without a table scan. A frame
// match or a delete miss scans the table one entry per cycle. A delete hit then moves the
// later entries down one per cycle.
// Throughput: one add or message byte per cycle while the queue and result output are not held;
// one match per frame, set by the table scan.
// Reset (aresetn low, synchronous): table empty, frame buffer empty, queue and output cleared.
// ============================================================================
// event_table_match_dispatch
// Ordered subscription table with add, delete and frame-triggered dispatch.
// ============================================================================
`default_nettype none

module event_table_match_dispatch #(
    parameter int TABLE_DEPTH = etmd_pkg::DEF_TABLE_DEPTH,
    parameter int FRAME_SIZE  = etmd_pkg::DEF_FRAME_SIZE
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // request channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tag_index[31:0], event_number[63:32], handle[95:64],
    // handler_present[96], rx_byte[104:97], zero pad above
    input  wire logic [etmd_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]                     s_tuser,
    // result channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // hit_index[31:0], hit_event[63:32], hit_handle[95:64],
    // call_handler[96], zero pad above
    output logic [etmd_pkg::M_TDATA_W-1:0]      m_tdata,
    // status[2:0]
    output logic [2:0]                          m_tuser
);
    import etmd_pkg::*;

    // Front: takes requests, tracks the frame byte count and captures the
    // index and event words; decodes each request into an operation.
    op_t     fr_op;
    logic    fr_push;
    logic    q_full;

    // Queue: lets the front keep taking bytes while the back scans.
    op_t     q_op;
    logic    q_valid;
    logic    q_pop;

    // Back: table memory, scan/shift sequencer and the output register.
    result_t res;

    etmd_front #(
        .FRAME_SIZE (FRAME_SIZE)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (fr_push),
        .q_op     (fr_op)
    );

    etmd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fr_push),
        .push_op (fr_op),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .pop_op  (q_op)
    );

    etmd_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (q_valid),
        .op       (q_op),
        .op_pop   (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res      (res)
    );

    // hit fields are zero in every result but a successful dispatch
    assign m_tdata = {{M_PAD_W{1'b0}}, res.call, res.handle, res.evt, res.index};
    assign m_tuser = res.status;

endmodule

`default_nettype wire

// ===== sv/etmd_front.sv =====
// ============================================================================
// etmd_front
// Accepts requests, assembles message frames and emits decoded operations.
// ============================================================================
`default_nettype none

module etmd_front #(
    parameter int FRAME_SIZE = etmd_pkg::DEF_FRAME_SIZE
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [etmd_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [1:0]                     s_tuser,
    input  wire logic                           q_full,
    output logic                                q_push,
    output etmd_pkg::op_t                       q_op
);
    import etmd_pkg::*;

    localparam int BW = $clog2(FRAME_SIZE);

    logic [BW-1:0] bytes_held_reg;
    logic [BW-1:0] bytes_held_next;
    logic [63:0]   word_reg;
    logic [63:0]   word_next;
    logic          frame_last;
    logic          capture;
    logic          is_byte;
    logic [7:0]    rx_byte;

    assign s_tready   = !q_full;
    assign q_push     = s_tvalid && !q_full;
    assign rx_byte    = s_tdata[104:97];
    assign is_byte    = q_push && (s_tuser == CMD_BYTE);
    assign frame_last = (bytes_held_reg == BW'(FRAME_SIZE - 1));
    assign capture    = (bytes_held_reg >= BW'(INDEX_POS)) &&
                        (bytes_held_reg < BW'(EVENT_POS + WORD_BYTES));

    always_comb begin
        q_op.kind        = OP_NOP;
        q_op.tag         = s_tdata[31:0];
        q_op.evt         = s_tdata[63:32];
        q_op.handle      = s_tdata[95:64];
        q_op.has_handler = s_tdata[96];
        unique case (s_tuser)
            CMD_ADD: begin
                q_op.kind = OP_ADD;
            end
            CMD_DEL: begin
                q_op.kind = OP_DEL;
            end
            CMD_BYTE: begin
                // index and event words are complete long before the last byte
                q_op.kind = frame_last ? OP_MATCH : OP_PARTIAL;
                q_op.tag  = word_reg[63:32];
                q_op.evt  = word_reg[31:0];
            end
            default: begin
                q_op.kind = OP_NOP;
            end
        endcase
    end

    always_comb begin
        bytes_held_next = bytes_held_reg;
        word_next       = word_reg;
        if (is_byte) begin
            bytes_held_next = frame_last ? '0 : bytes_held_reg + BW'(1);
            if (capture) begin
                word_next = {word_reg[55:0], rx_byte};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_held_reg <= '0;
        end else begin
            bytes_held_reg <= bytes_held_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

endmodule

`default_nettype wire

// ===== sv/etmd_queue.sv =====
// ============================================================================
// etmd_queue
// Short FIFO of decoded operations between front and back.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module etmd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire etmd_pkg::op_t push_op,
    output logic               full,
    input  wire logic          pop,
    output logic               valid,
    output etmd_pkg::op_t      pop_op
);
    import etmd_pkg::*;

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_pop;

    assign full   = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid  = (cnt_reg != '0);
    assign do_pop = pop && valid;
    assign pop_op = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !do_pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (!push && do_pop) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    `ETMD_NEVER(a_q_overflow, aclk, aresetn, push && full, "queue push while full")

endmodule

`default_nettype wire

// ===== sv/etmd_back.sv =====
// ============================================================================
// etmd_back
// Executes operations on the subscription table and holds the result.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module etmd_back #(
    parameter int TABLE_DEPTH = etmd_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          op_valid,
    input  wire etmd_pkg::op_t op,
    output logic               op_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output etmd_pkg::result_t  res
);
    import etmd_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        BK_IDLE  = 3'b001,
        BK_SCAN  = 3'b010,
        BK_SHIFT = 3'b100
    } bk_state_t;

    bk_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0] cmp_ptr_reg, cmp_ptr_next;
    logic          cmp_vld_reg, cmp_vld_next;
    op_t           op_reg, op_next;
    logic          m_tvalid_reg;
    result_t       res_reg, res_next;
    logic          res_load;

    entry_t        mem [TABLE_DEPTH];
    entry_t        rdata_reg;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_waddr;
    logic          mem_we;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] shift_dst;

    logic out_free;
    logic issue;
    logic hit;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign issue     = (scan_ptr_reg < count_reg);
    assign hit       = cmp_vld_reg && (rdata_reg.tag == op_reg.tag) &&
                       (rdata_reg.evt == op_reg.evt);
    assign rd_addr   = scan_ptr_reg[AW-1:0];
    assign shift_dst = cmp_ptr_reg - CW'(1);
    assign m_tvalid  = m_tvalid_reg;
    assign res       = res_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_ptr_next = scan_ptr_reg;
        cmp_ptr_next  = scan_ptr_reg;
        cmp_vld_next  = 1'b0;
        op_next       = op_reg;
        op_pop        = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[AW-1:0];
        mem_wdata.tag         = op.tag;
        mem_wdata.evt         = op.evt;
        mem_wdata.handle      = op.handle;
        mem_wdata.has_handler = op.has_handler;
        res_load      = 1'b0;
        res_next      = '0;
        unique case (state_reg)
            BK_IDLE: begin
                if (op_valid && out_free) begin
                    op_pop  = 1'b1;
                    op_next = op;
                    unique case (op.kind) inside
                        OP_ADD: begin
                            res_load = 1'b1;
                            if (count_reg == CW'(TABLE_DEPTH)) begin
                                res_next.status = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_DEL, OP_MATCH: begin
                            state_next    = BK_SCAN;
                            scan_ptr_next = '0;
                        end
                        OP_PARTIAL: begin
                            res_load        = 1'b1;
                            res_next.status = ST_PARTIAL;
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            BK_SCAN: begin
                // one read issued and one entry compared per cycle
                cmp_vld_next = issue;
                if (issue) begin
                    scan_ptr_next = scan_ptr_reg + CW'(1);
                end
                if (hit) begin
                    if (op_reg.kind == OP_MATCH) begin
                        res_load        = 1'b1;
                        res_next.index  = op_reg.tag;
                        res_next.evt    = op_reg.evt;
                        res_next.handle = rdata_reg.handle;
                        res_next.call   = rdata_reg.has_handler;
                        state_next      = BK_IDLE;
                    end else begin
                        state_next    = BK_SHIFT;
                        scan_ptr_next = cmp_ptr_reg + CW'(1);
                        cmp_vld_next  = 1'b0;
                    end
                end else if (!cmp_vld_reg && !issue) begin
                    res_load        = 1'b1;
                    res_next.status = (op_reg.kind == OP_MATCH) ? ST_UNKNOWN : ST_NOTFOUND;
                    state_next      = BK_IDLE;
                end
            end
            BK_SHIFT: begin
                // entry read last cycle moves down one slot
                cmp_vld_next = issue;
                if (issue) begin
                    scan_ptr_next = scan_ptr_reg + CW'(1);
                end
                if (cmp_vld_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = shift_dst[AW-1:0];
                    mem_wdata = rdata_reg;
                end else if (!issue) begin
                    count_next = count_reg - CW'(1);
                    res_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            count_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            if (res_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_ptr_reg <= scan_ptr_next;
        cmp_ptr_reg  <= cmp_ptr_next;
        op_reg       <= op_next;
        if (res_load) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    `ETMD_ASSERT(a_count_bound, aclk, aresetn,
                 count_reg <= CW'(TABLE_DEPTH), "entry count above depth")
    `ETMD_ASSERT(a_shift_nonempty, aclk, aresetn,
                 (state_reg == BK_SHIFT) |-> (count_reg != '0), "shift on empty table")
    `ETMD_ASSERT(a_res_no_overrun, aclk, aresetn,
                 res_load |-> (!m_tvalid_reg || m_tready), "result register overrun")

endmodule

`default_nettype wire
